@@ rtl/bds_pkg.sv @@
// Shared types, constants and the tap table of the 28 to 16 bilinear downscaler.
package bds_pkg;

   localparam int SRC_SIDE = 28;
   localparam int DST_SIDE = 16;

   localparam int POS_W = 5;
   localparam int DST_W = 4;
   localparam int PIX_W = 8;
   localparam int WGT_W = 4;
   localparam int ROW_W = 11;
   localparam int VAL_W = 14;

   localparam logic [POS_W-1:0] LAST_POS = POS_W'(SRC_SIDE - 1);
   localparam logic [DST_W-1:0] LAST_DST = DST_W'(DST_SIDE - 1);
   localparam logic [WGT_W-1:0] WGT_ONE  = WGT_W'(8);

   typedef struct packed {
      logic             hit;
      logic [DST_W-1:0] dst;
      logic [WGT_W-1:0] wgt;
   } tap_type;

   typedef struct packed {
      logic             en;
      logic [POS_W-1:0] addr;
      logic [PIX_W-1:0] data;
   } mem_wr_type;

   // Destination index whose lower source tap is k, with its upper weight in eighths.
   function automatic tap_type tap_of(input logic [POS_W-1:0] k);
      tap_type t;
      t = '{hit: 1'b1, dst: '0, wgt: '0};
      case (k)
         5'd0:    begin t.dst = 4'd0;  t.wgt = 4'd3; end
         5'd2:    begin t.dst = 4'd1;  t.wgt = 4'd1; end
         5'd3:    begin t.dst = 4'd2;  t.wgt = 4'd7; end
         5'd5:    begin t.dst = 4'd3;  t.wgt = 4'd5; end
         5'd7:    begin t.dst = 4'd4;  t.wgt = 4'd3; end
         5'd9:    begin t.dst = 4'd5;  t.wgt = 4'd1; end
         5'd10:   begin t.dst = 4'd6;  t.wgt = 4'd7; end
         5'd12:   begin t.dst = 4'd7;  t.wgt = 4'd5; end
         5'd14:   begin t.dst = 4'd8;  t.wgt = 4'd3; end
         5'd16:   begin t.dst = 4'd9;  t.wgt = 4'd1; end
         5'd17:   begin t.dst = 4'd10; t.wgt = 4'd7; end
         5'd19:   begin t.dst = 4'd11; t.wgt = 4'd5; end
         5'd21:   begin t.dst = 4'd12; t.wgt = 4'd3; end
         5'd23:   begin t.dst = 4'd13; t.wgt = 4'd1; end
         5'd24:   begin t.dst = 4'd14; t.wgt = 4'd7; end
         5'd26:   begin t.dst = 4'd15; t.wgt = 4'd5; end
         default: t.hit = 1'b0;
      endcase
      return t;
   endfunction

endpackage

@@ rtl/bilinear_downscale_28_to_16.sv @@
// Top level of the 28x28 to 16x16 bilinear downscaler with half-pixel centers.
//
//   Channel   Direction  Payload                                    Handshake
//   req_      in         pixel[7:0], frame_start                    req_valid / req_stall
//   rsp_      out        value[13:0], out_col, out_row, frame_last  rsp_valid / rsp_stall
//
// The block accepts one source pixel per clock while req_stall is low. The edge that
// accepts a pixel also registers its line memory read in stage 1. Stage 2 registers
// the horizontal blend, and the output register then takes the vertical blend.
// Reset clears the position counters, the neighbor pixels and all stage valid flags.
// The line memory is not cleared; row 0 fills it before any entry is used.
// A stall with a result held freezes the whole pipeline and raises req_stall.
module bilinear_downscale_28_to_16 (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [bds_pkg::PIX_W-1:0] req_pixel,
   input  logic                      req_frame_start,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [bds_pkg::VAL_W-1:0] rsp_value,
   output logic [bds_pkg::DST_W-1:0] rsp_out_col,
   output logic [bds_pkg::DST_W-1:0] rsp_out_row,
   output logic                      rsp_frame_last
);
   import bds_pkg::*;

   // Pipeline moves as one whenever the output register is empty or being drained.
   logic advance;
   logic accept;

   assign advance   = !rsp_valid || !rsp_stall;
   assign req_stall = !advance;
   assign accept    = req_valid && advance;

   // Position of the next source pixel.
   logic [POS_W-1:0] row_ff, row_in;
   logic [POS_W-1:0] col_ff, col_in;
   logic [POS_W-1:0] cur_row, cur_col;

   assign cur_row = req_frame_start ? '0 : row_ff;
   assign cur_col = req_frame_start ? '0 : col_ff;

   always_comb begin
      row_in = cur_row;
      col_in = cur_col + POS_W'(1);
      if (cur_col == LAST_POS) begin
         col_in = '0;
         row_in = (cur_row == LAST_POS) ? '0 : cur_row + POS_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else if (accept) begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

   // A pixel at (r, c) closes the destination pixel whose lower taps are (r-1, c-1).
   tap_type tap_y, tap_x;
   logic    closes;

   assign tap_y  = tap_of(cur_row - POS_W'(1));
   assign tap_x  = tap_of(cur_col - POS_W'(1));
   assign closes = (cur_row != '0) && (cur_col != '0) && tap_y.hit && tap_x.hit;

   // Stage 1: the line memory read of the pixel above is in flight.
   logic             s1_valid_ff;
   logic             s1_hit_ff;
   logic [PIX_W-1:0] s1_pixel_ff;
   logic [POS_W-1:0] s1_col_ff;
   tap_type          s1_tap_y_ff, s1_tap_x_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_hit_ff   <= closes;
         s1_pixel_ff <= req_pixel;
         s1_col_ff   <= cur_col;
         s1_tap_y_ff <= tap_y;
         s1_tap_x_ff <= tap_x;
      end
   end

   logic        s1_fire;
   mem_wr_type  mem_wr;
   logic [PIX_W-1:0] above;

   assign s1_fire = advance && s1_valid_ff;

   // The current pixel replaces the previous row's byte in its column.
   assign mem_wr = '{en: s1_fire, addr: s1_col_ff, data: s1_pixel_ff};

   bds_line_mem u_line_mem (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (cur_col),
      .wr      (mem_wr),
      .rd_data (above)
   );

   // Neighbors of the pixel in stage 1: its left pixel and the one above that.
   logic [PIX_W-1:0] left_ff;
   logic [PIX_W-1:0] upper_left_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff       <= '0;
         upper_left_ff <= '0;
      end else if (s1_fire) begin
         left_ff       <= s1_pixel_ff;
         upper_left_ff <= above;
      end
   end

   // Horizontal blend of the upper and lower tap pairs.
   logic [WGT_W-1:0] wx_lo;
   logic [ROW_W-1:0] top_in, bot_in;

   assign wx_lo  = WGT_ONE - s1_tap_x_ff.wgt;
   assign top_in = ROW_W'(upper_left_ff * wx_lo) + ROW_W'(above * s1_tap_x_ff.wgt);
   assign bot_in = ROW_W'(left_ff * wx_lo) + ROW_W'(s1_pixel_ff * s1_tap_x_ff.wgt);

   // Stage 2: row blends wait for the vertical blend.
   logic             s2_valid_ff;
   logic [ROW_W-1:0] s2_top_ff, s2_bot_ff;
   logic [WGT_W-1:0] s2_wy_ff;
   logic [DST_W-1:0] s2_col_ff, s2_row_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff && s1_hit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         s2_top_ff <= top_in;
         s2_bot_ff <= bot_in;
         s2_wy_ff  <= s1_tap_y_ff.wgt;
         s2_col_ff <= s1_tap_x_ff.dst;
         s2_row_ff <= s1_tap_y_ff.dst;
      end
   end

   logic [WGT_W-1:0] wy_lo;
   logic [VAL_W-1:0] value_in;

   assign wy_lo    = WGT_ONE - s2_wy_ff;
   assign value_in = VAL_W'(s2_top_ff * wy_lo) + VAL_W'(s2_bot_ff * s2_wy_ff);

   // Output register: holds a finished request's result until it is taken.
   logic             out_valid_ff;
   logic [VAL_W-1:0] out_value_ff;
   logic [DST_W-1:0] out_col_ff, out_row_ff;
   logic             out_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && s2_valid_ff) begin
         out_value_ff <= value_in;
         out_col_ff   <= s2_col_ff;
         out_row_ff   <= s2_row_ff;
         out_last_ff  <= (s2_col_ff == LAST_DST) && (s2_row_ff == LAST_DST);
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_value      = out_value_ff;
   assign rsp_out_col    = out_col_ff;
   assign rsp_out_row    = out_row_ff;
   assign rsp_frame_last = out_last_ff;

endmodule

@@ rtl/bds_line_mem.sv @@
// Line memory of the previous source row, registered read with write forwarding.
module bds_line_mem (
   input  logic                      clock,
   input  logic                      rd_en,
   input  logic [bds_pkg::POS_W-1:0] rd_addr,
   input  bds_pkg::mem_wr_type       wr,
   output logic [bds_pkg::PIX_W-1:0] rd_data
);
   import bds_pkg::*;

   logic [PIX_W-1:0] mem [SRC_SIDE];
   logic [PIX_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // A write to the entry being read in the same cycle returns the new byte.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr.en && wr.addr == rd_addr) begin
            rd_data_ff <= wr.data;
         end else begin
            rd_data_ff <= mem[rd_addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sim/bilinear_downscale_28_to_16_tb.sv @@
// Self-checking testbench of the 28x28 to 16x16 bilinear downscaler with random idling.
`timescale 1ns / 1ps

// The bench drives source pixels into the request channel and checks every result that
// leaves the response channel against a scoreboard.
//
// Its predictor keeps a private copy of the image state: the line of the row above, the
// two neighbor pixels and the row and column position. It computes the lower tap and
// weight of every destination index from the half-pixel center formula. The tap table
// in the package is not used.
//
// Stimulus comes in two parts. First a table of segments is walked. Each segment is a
// run of pixels that opens with or without a frame start. Flat fills have their result
// typed into the table; one of them ends a row on column zero. Ramps, noise, an
// abandoned frame, a whole frame and a run that follows the counter wrap without a frame
// start are checked against the predictor. Then random segments follow: cut-off frames
// and loose pixels with scattered frame starts, all of random content.
module bilinear_downscale_28_to_16_tb;
   import bds_pkg::*;

   typedef enum logic [1:0] {PAT_FILL, PAT_RAMP, PAT_NOISE} pattern_type;

   // One directed segment: count pixels of one pattern. The frame start flag applies
   // to its first pixel only.
   typedef struct {
      logic         fs;
      int unsigned  count;
      pattern_type  kind;
      logic [7:0]   level;
      logic         typed;
      logic [13:0]  typed_value;
   } segment_type;

   typedef struct packed {
      logic [VAL_W-1:0] value;
      logic [DST_W-1:0] col;
      logic [DST_W-1:0] row;
      logic             last;
   } dst_pixel_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [PIX_W-1:0]    req_pixel = '0;
   logic                req_frame_start = 1'b0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [VAL_W-1:0]    rsp_value;
   logic [DST_W-1:0]    rsp_out_col;
   logic [DST_W-1:0]    rsp_out_row;
   logic                rsp_frame_last;

   // This is the predictor's private copy of the image state.
   logic [7:0]          row_above [SRC_SIDE];
   logic [7:0]          west_pix = '0;
   logic [7:0]          northwest_pix = '0;
   int unsigned         cur_row = 0;
   int unsigned         cur_col = 0;

   // Destination pixels that are predicted but not yet seen, oldest first.
   dst_pixel_type       pending_pixels[$];
   int unsigned         mismatch_count = 0;

   // When typed_on is set, the value of each predicted pixel is replaced by the one
   // typed into the directed table. Row and column still come from the predictor.
   logic                typed_on = 1'b0;
   logic [VAL_W-1:0]    typed_level = '0;

   int unsigned         calm_left = 0;
   int unsigned         stall_left = 0;
   int unsigned         open_left = 0;

   bilinear_downscale_28_to_16 u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_pixel       (req_pixel),
      .req_frame_start (req_frame_start),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_value       (rsp_value),
      .rsp_out_col     (rsp_out_col),
      .rsp_out_row     (rsp_out_row),
      .rsp_frame_last  (rsp_frame_last)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      #30_000_000;
      $display("bilinear_downscale_28_to_16_tb: errors");
      $finish;
   end

   // Most idle stretches are empty or short. A few run long.
   function automatic int unsigned idle_len();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 50) return 0;
      if (pick < 85) return $urandom_range(1, 3);
      if (pick < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Finds the destination index whose lower source tap is k. The sample point of
   // destination o is ((o + 1/2) * 28/16 - 1/2), taken here in eighths.
   // Only destination indexes whose upper tap is still inside the image count.
   function automatic void tap_to_dest(input int unsigned k, output logic hit,
                                       output logic [DST_W-1:0] dst,
                                       output int unsigned wgt);
      int unsigned eighths;
      hit = 1'b0;
      dst = '0;
      wgt = 0;
      for (int o = 0; o < DST_SIDE; o++) begin
         eighths = ((8 * o + 4) * SRC_SIDE) / DST_SIDE - 4;
         if (!hit && (eighths >> 3) == k && k + 1 < SRC_SIDE) begin
            hit = 1'b1;
            dst = DST_W'(o);
            wgt = eighths & 7;
         end
      end
   endfunction

   // Advances the image state by one source pixel. The function returns 1 when this
   // pixel completes a destination pixel, which is the lower right corner of its
   // 2x2 neighborhood.
   function automatic bit scale_step(input logic [7:0] pix, input logic fs,
                                     output dst_pixel_type res);
      logic [7:0]       above;
      logic             row_hit, col_hit;
      logic [DST_W-1:0] oy, ox;
      int unsigned      wy, wx, top, bot;
      bit               made;
      made = 1'b0;
      res  = '0;
      if (fs) begin
         cur_row = 0;
         cur_col = 0;
      end
      above = row_above[cur_col];
      if (cur_row >= 1 && cur_col >= 1) begin
         tap_to_dest(cur_row - 1, row_hit, oy, wy);
         tap_to_dest(cur_col - 1, col_hit, ox, wx);
         if (row_hit && col_hit) begin
            top = northwest_pix * (8 - wx) + above * wx;
            bot = west_pix * (8 - wx) + pix * wx;
            res.value = VAL_W'(top * (8 - wy) + bot * wy);
            res.col   = ox;
            res.row   = oy;
            res.last  = (oy == LAST_DST) && (ox == LAST_DST);
            made = 1'b1;
         end
      end
      northwest_pix     = above;
      row_above[cur_col] = pix;
      west_pix          = pix;
      cur_col++;
      if (cur_col == SRC_SIDE) begin
         cur_col = 0;
         cur_row = (cur_row == SRC_SIDE - 1) ? 0 : cur_row + 1;
      end
      return made;
   endfunction

   // Sends one request. An idle gap may come first, and the payload is held until the
   // block accepts it. The task returns in the time step of the accepting edge, so a
   // following request with no gap keeps req_valid high without a glitch.
   task automatic push_pixel(input logic [7:0] pix, input logic fs);
      int unsigned   gap;
      dst_pixel_type res;
      if (calm_left > 0) begin
         calm_left--;
         gap = 0;
      end else begin
         gap = idle_len();
         if ($urandom_range(0, 49) == 0) calm_left = $urandom_range(50, 300);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_pixel       <= pix;
      req_frame_start <= fs;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (scale_step(pix, fs, res)) begin
         if (typed_on) res.value = typed_level;
         pending_pixels = {pending_pixels, res};
      end
   endtask

   // This block checks the response side and drives its stall pattern. The stall
   // alternates short open and stalled stretches, with an occasional long stretch
   // that has no stall at all.
   always @(posedge clock) begin
      dst_pixel_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_pixels.size() == 0) begin
            $display("%0t: result expected none actual value %0d col %0d row %0d last %0d",
                     $time, rsp_value, rsp_out_col, rsp_out_row, rsp_frame_last);
            mismatch_count++;
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_value !== want.value) begin
               $display("%0t: rsp_value expected %0d actual %0d",
                        $time, want.value, rsp_value);
               mismatch_count++;
            end
            if (rsp_out_col !== want.col) begin
               $display("%0t: rsp_out_col expected %0d actual %0d",
                        $time, want.col, rsp_out_col);
               mismatch_count++;
            end
            if (rsp_out_row !== want.row) begin
               $display("%0t: rsp_out_row expected %0d actual %0d",
                        $time, want.row, rsp_out_row);
               mismatch_count++;
            end
            if (rsp_frame_last !== want.last) begin
               $display("%0t: rsp_frame_last expected %0d actual %0d",
                        $time, want.last, rsp_frame_last);
               mismatch_count++;
            end
         end
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (open_left > 0) begin
         open_left--;
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= 1'b0;
         if ($urandom_range(0, 39) == 0) begin
            open_left = $urandom_range(100, 400);
         end else begin
            open_left  = $urandom_range(0, 5);
            stall_left = idle_len();
         end
      end
   end

   initial begin
      segment_type plan [8];
      int unsigned sent;
      int unsigned len;
      int unsigned style;
      logic [7:0]  pix;
      logic [7:0]  base;
      logic        fs;

      foreach (row_above[i]) row_above[i] = '0;

      // Row 0 fills the line before any result. So a flat fill of level v gives
      // 64*v on every destination pixel of the segment, and these values are typed in.
      plan[0] = '{1'b1,  56, PAT_FILL,  8'd0,   1'b1, 14'd0};
      plan[1] = '{1'b1,  56, PAT_FILL,  8'd255, 1'b1, 14'd16320};
      // This frame is abandoned in its second row, and the next frame start restarts it.
      plan[2] = '{1'b1,  40, PAT_NOISE, 8'd0,   1'b0, 14'd0};
      // This is a whole frame, so the final destination pixel carries frame_last.
      // The counters wrap on their own after its 28x28 pixels.
      plan[3] = '{1'b1, 784, PAT_RAMP,  8'd0,   1'b0, 14'd0};
      // These two rows have no frame start and rely on that wrap to begin at row 0.
      plan[4] = '{1'b0,  56, PAT_NOISE, 8'd0,   1'b0, 14'd0};
      // This fill continues in rows 2 and 3 and closes one destination pixel of row 1.
      plan[5] = '{1'b0,  30, PAT_FILL,  8'd128, 1'b1, 14'd8192};
      // This segment ends on column zero of row 1, which must complete nothing.
      plan[6] = '{1'b1,  29, PAT_FILL,  8'd1,   1'b1, 14'd64};
      plan[7] = '{1'b1,  30, PAT_FILL,  8'd64,  1'b1, 14'd4096};

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[s]) begin
         typed_on    = plan[s].typed;
         typed_level = plan[s].typed_value;
         for (int i = 0; i < plan[s].count; i++) begin
            case (plan[s].kind)
               PAT_FILL:  pix = plan[s].level;
               PAT_RAMP:  pix = 8'(i * 37 + i / SRC_SIDE);
               default:   pix = 8'($urandom_range(0, 255));
            endcase
            push_pixel(pix, plan[s].fs && i == 0);
         end
      end
      typed_on = 1'b0;

      // In the random part, most segments are frames cut off after a few rows. The
      // rest are short cut-off frames and loose pixels with stray frame starts.
      sent = 0;
      while (sent < 100) begin
         case ($urandom_range(0, 9))
            7, 8: begin
               len = $urandom_range(1, 40);
               fs  = 1'b1;
            end
            9: begin
               len = $urandom_range(1, 60);
               fs  = 1'b0;
            end
            default: begin
               len = $urandom_range(29, 120);
               fs  = 1'b1;
            end
         endcase
         style = $urandom_range(0, 2);
         base  = 8'($urandom_range(0, 255));
         for (int i = 0; i < len; i++) begin
            case (style)
               0:       pix = 8'($urandom_range(0, 255));
               1:       pix = $urandom_range(0, 1) ? 8'hFF : 8'h00;
               default: pix = base + 8'($urandom_range(0, 15));
            endcase
            if (fs == 1'b0)
               push_pixel(pix, $urandom_range(0, 39) == 0);
            else
               push_pixel(pix, fs && i == 0);
         end
         sent += len;
      end

      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0)
         $display("bilinear_downscale_28_to_16_tb: clean");
      else
         $display("bilinear_downscale_28_to_16_tb: errors");
      $finish;
   end

endmodule

@@ bilinear_downscale_28_to_16.f @@
rtl/bds_pkg.sv
rtl/bds_line_mem.sv
rtl/bilinear_downscale_28_to_16.sv
sim/bilinear_downscale_28_to_16_tb.sv
